/* sv/fcil_pkg.sv */
// Package for the four-channel IIR low-pass unit.
// Holds coefficient reset values, register indexes, the channel state type
// and the saturating Q-format arithmetic helpers. No dependencies.
package fcil_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 2;
    localparam int DATA_W   = 32;
    localparam int COEFF_W  = 16;
    localparam int FRAC_SH  = 15;

    localparam logic signed [COEFF_W-1:0] FB_COEFF_RESET = 16'sh7EAB;
    localparam logic signed [DATA_W-1:0]  IN_GAIN_RESET  = 32'sh00AAB172;

    typedef logic [0:0] cfg_index_t;

    typedef enum logic [0:0] {
        REG_FEEDBACK_COEFF = 1'b0,
        REG_INPUT_GAIN     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] kx;
        logic signed [DATA_W-1:0] y;
    } chan_state_t;

    function automatic logic signed [DATA_W-1:0] sat_to_32(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat_to_32(s);
    endfunction

    // Q31 x Q15, floor shift by 15, saturate
    function automatic logic signed [DATA_W-1:0] mul_q31_q15(input logic signed [DATA_W-1:0] a,
                                                             input logic signed [COEFF_W-1:0] b);
        logic signed [DATA_W+COEFF_W-1:0] p;
        logic signed [DATA_W:0]           q;
        p = a * b;
        q = p[DATA_W+COEFF_W-1:FRAC_SH];
        return sat_to_32(q);
    endfunction

endpackage

/* sv/four_channel_iir_lowpass_unit.sv */
// Top level of the four-channel first-order IIR low-pass unit.
// Uses fcil_pkg, fcil_state and fcil_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries a Q15 sample and a channel number.
//   Output channel (out_valid/out_stall) returns one Q31 result per transfer:
//   y = K*(x + x_prev) + a1*y_prev, products and sums saturated to 32 bits.
//   A channel number at or above NUM_CHANNELS returns 0 and leaves state alone.
//   Config channel (cfg_valid/cfg_ready) writes feedback_coeff (index 0, Q15)
//   or input_gain (index 1, Q31); cfg_ready is always high. Write only when idle.
//   Throughput: one item per cycle while out_stall is low; each item passes
//   through the input register, then the result register. The filter update is
//   combinational between the two, and a channel's state is written at the same
//   edge as the result, so the same channel may repeat at once.
//   Reset clears all channel state and loads the coefficient reset values.
//   When the receiver stalls, the result is held; one more item is taken into
//   the input register, then in_stall rises until the result is taken.
module four_channel_iir_lowpass_unit
#(
    parameter int unsigned NUM_CHANNELS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  sample,
    input  logic [1:0]          channel,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  filtered,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  fcil_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data
);
    import fcil_pkg::*;

    logic signed [COEFF_W-1:0] feedback_coeff_reg;
    logic signed [COEFF_W-1:0] feedback_coeff_next;
    logic signed [DATA_W-1:0]  input_gain_reg;
    logic signed [DATA_W-1:0]  input_gain_next;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [CHAN_W-1:0]         channel_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DATA_W-1:0]  filtered_reg;
    logic signed [DATA_W-1:0]  filtered_next;

    logic                      out_free;
    logic                      load;
    logic                      accept;
    logic                      present;
    chan_state_t               prev_state;
    chan_state_t               new_state;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        feedback_coeff_next = feedback_coeff_reg;
        input_gain_next     = input_gain_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FEEDBACK_COEFF: feedback_coeff_next = cfg_data[COEFF_W-1:0];
                REG_INPUT_GAIN:     input_gain_next     = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_coeff_reg <= FB_COEFF_RESET;
            input_gain_reg     <= IN_GAIN_RESET;
        end
        else
        begin
            feedback_coeff_reg <= feedback_coeff_next;
            input_gain_reg     <= input_gain_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
        end

        filtered_next = present ? new_state.y : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= sample;
            channel_reg <= channel;
        end
        if (load)
        begin
            filtered_reg <= filtered_next;
        end
    end

    fcil_state #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .channel (channel_reg),
        .wr_en   (load && present),
        .wr_data (new_state),
        .rd_data (prev_state),
        .present (present)
    );

    fcil_datapath u_datapath (
        .sample         (sample_reg),
        .feedback_coeff (feedback_coeff_reg),
        .input_gain     (input_gain_reg),
        .prev           (prev_state),
        .next           (new_state)
    );

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled while a stage is free");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("held input item lost");

    a_absent_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !present) |=> (out_valid && filtered == '0))
        else $error("absent channel gave nonzero result");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("result transfer not presented");

endmodule

/* sv/fcil_datapath.sv */
// Filter arithmetic for one sample: two products and two saturating adds.
// Purely combinational; depends on fcil_pkg.
module fcil_datapath
(
    input  logic signed [15:0]   sample,
    input  logic signed [15:0]   feedback_coeff,
    input  logic signed [31:0]   input_gain,
    input  fcil_pkg::chan_state_t prev,
    output fcil_pkg::chan_state_t next
);
    import fcil_pkg::*;

    logic signed [DATA_W-1:0] kx;
    logic signed [DATA_W-1:0] fb;
    logic signed [DATA_W-1:0] fb_sum;

    always_comb
    begin
        kx     = mul_q31_q15(input_gain, sample);
        fb     = mul_q31_q15(prev.y, feedback_coeff);
        fb_sum = sat_add(fb, prev.kx);
        next.kx = kx;
        next.y  = sat_add(kx, fb_sum);
    end

endmodule

/* sv/fcil_state.sv */
// Per-channel filter state: K*x_prev and y_prev for each channel.
// Selects the addressed channel and updates it on write; depends on fcil_pkg.
module fcil_state
#(
    parameter int unsigned NUM_CHANNELS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            channel,
    input  logic                  wr_en,
    input  fcil_pkg::chan_state_t wr_data,
    output fcil_pkg::chan_state_t rd_data,
    output logic                  present
);
    import fcil_pkg::*;

    chan_state_t state_reg [NUM_CHANNELS];

    always_comb
    begin
        rd_data = '0;
        present = (int'(channel) < int'(NUM_CHANNELS));
        for (int i = 0; i < int'(NUM_CHANNELS); i++)
        begin
            if (int'(channel) == i)
            begin
                rd_data = state_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(NUM_CHANNELS); i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < int'(NUM_CHANNELS); i++)
            begin
                if (wr_en && int'(channel) == i)
                begin
                    state_reg[i] <= wr_data;
                end
            end
        end
    end

endmodule

/* tb/fcil_iir_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for four_channel_iir_lowpass_unit. It watches the sample, result and
// register transfers, predicts each filtered value and checks results in order.
// Depends on fcil_pkg for the register indexes and the coefficient reset values.
module fcil_iir_checker
#(
    parameter int unsigned NUM_CHANNELS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [15:0]   sample,
    input  logic [1:0]           channel,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [31:0]   filtered,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  fcil_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   error_count,
    output int                   pending,
    output int                   results_checked
);
    import fcil_pkg::*;

    localparam longint Q31_MAX = 64'sd2147483647;
    localparam longint Q31_MIN = -64'sd2147483648;
    localparam int     MAX_PRINTED = 40;

    logic signed [15:0] pole;
    logic signed [31:0] gain;
    logic signed [31:0] last_kx [NUM_CHANNELS];
    logic signed [31:0] last_y  [NUM_CHANNELS];
    logic signed [31:0] expected_filtered [$];
    logic signed [31:0] want;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > Q31_MAX)
            return Q31_MAX[31:0];
        if (v < Q31_MIN)
            return Q31_MIN[31:0];
        return v[31:0];
    endfunction

    // exact product, floor shift by 15, clamp
    function automatic logic signed [31:0] scale_q15(input logic signed [31:0] a,
                                                     input logic signed [15:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> 15);
    endfunction

    function automatic logic signed [31:0] filter_step(input logic signed [15:0] x,
                                                       input logic [1:0] ch);
        logic signed [31:0] kx;
        logic signed [31:0] fb;
        logic signed [31:0] y;
        if (ch >= NUM_CHANNELS)
            return '0;
        kx = scale_q15(gain, x);
        fb = clamp32(longint'(scale_q15(last_y[ch], pole)) + longint'(last_kx[ch]));
        y  = clamp32(longint'(kx) + longint'(fb));
        last_kx[ch] = kx;
        last_y[ch]  = y;
        return y;
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole = FB_COEFF_RESET;
            gain = IN_GAIN_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_kx[i] = '0;
                last_y[i]  = '0;
            end
            expected_filtered.delete();
            error_count     = 0;
            pending         = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FEEDBACK_COEFF: pole = cfg_data[15:0];
                    REG_INPUT_GAIN:     gain = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_filtered.size() == 0)
                begin
                    flag_mismatch($sformatf("result %0d with nothing expected", filtered));
                end
                else
                begin
                    want = expected_filtered.pop_front();
                    results_checked++;
                    if (filtered !== want)
                        flag_mismatch($sformatf("filtered %0d, expected %0d",
                                                filtered, want));
                end
            end
            if (in_valid && !in_stall)
                expected_filtered.push_back(filter_step(sample, channel));
            pending = expected_filtered.size();
        end
    end

endmodule

/* tb/four_channel_iir_lowpass_unit_tb.sv */
`timescale 1ns / 1ps
// Stimulus top for four_channel_iir_lowpass_unit: directed and random samples,
// coefficient changes between phases, random idling and a long output hold.
// Depends on fcil_pkg, the unit itself and fcil_iir_checker.
module four_channel_iir_lowpass_unit_tb;
    import fcil_pkg::*;

    localparam int SEGMENT_ITEMS = 50;
    localparam int HOLD_CYCLES   = 80;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic signed [15:0]  sample;
    logic [1:0]          channel;
    logic                out_valid;
    logic                out_stall;
    logic signed [31:0]  filtered;
    logic                cfg_valid;
    logic                cfg_ready;
    cfg_index_t          cfg_index;
    logic [31:0]         cfg_data;

    int   idle_pct;
    int   stall_pct;
    logic hold_request;
    bit   hold_done;
    int   items_sent;
    int   settings_used;
    int   error_count;
    int   pending;
    int   results_checked;

    four_channel_iir_lowpass_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .channel   (channel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fcil_iir_checker filter_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .channel         (channel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered        (filtered),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_pole();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return FB_COEFF_RESET;
            4:       return 16'sh7C00 + 16'($urandom_range(1023));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_gain();
        case ($urandom_range(5))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sh00000000;
            3:       return IN_GAIN_RESET;
            4:       return 32'($urandom_range(32'h00FFFFFF));
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic signed [15:0] x, input logic [1:0] ch);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= x;
        channel  <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // leaves cfg_valid high so back-to-back writes follow without a gap
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_coeffs(input logic signed [15:0] a1, input logic signed [31:0] k);
        write_reg(REG_FEEDBACK_COEFF, {{16{a1[15]}}, a1});
        write_reg(REG_INPUT_GAIN, k);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver side: random stalls plus one long hold to back up the pipeline
    initial
    begin
        out_stall <= 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        sample       <= '0;
        channel      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_FEEDBACK_COEFF;
        cfg_data     <= '0;
        hold_request <= 1'b0;
        idle_pct      = 6;
        stall_pct     = 45;
        items_sent    = 0;
        settings_used = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients, sample extremes, every channel, same channel back to back
        send_item(16'sh7FFF, 2'd0);
        send_item(16'sh8000, 2'd1);
        send_item(16'sh0000, 2'd2);
        send_item(-16'sd1,   2'd3);
        send_item(16'sd1,    2'd0);
        send_item(16'sh7FFF, 2'd0);
        send_item(16'sh8000, 2'd0);
        drain;

        // full-scale gain and pole: drive ch1 to negative and ch2 to positive rail
        set_coeffs(16'sh7FFF, 32'sh7FFFFFFF);
        send_item(16'sh8000, 2'd1);
        send_item(16'sh8000, 2'd1);
        send_item(16'sh8000, 2'd1);
        send_item(16'sh7FFF, 2'd2);
        send_item(16'sh7FFF, 2'd2);
        drain;

        // most negative gain and pole: both products overflow and clamp
        set_coeffs(16'sh8000, 32'sh80000000);
        send_item(16'sh8000, 2'd1);
        send_item(16'sh8000, 2'd3);
        send_item(16'sh7FFF, 2'd3);
        send_item(16'sh0000, 2'd2);
        drain;

        set_coeffs(16'sh0000, 32'sh00000000);
        send_item(16'sd12345, 2'd0);
        send_item(-16'sd1,    2'd1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 6;
                    stall_pct = 45;
                end
                1:
                begin
                    idle_pct  = 45;
                    stall_pct = 6;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                drain;
                set_coeffs(pick_pole(), pick_gain());
                if (phase == 2 && seg == 1)
                    hold_request <= 1'b1;
                for (int n = 0; n < SEGMENT_ITEMS; n++)
                    send_item(pick_sample(), 2'($urandom_range(3)));
            end
        end
        drain;

        $display("Covered %0d samples on all four channels under %0d coefficient settings,",
                 items_sent, settings_used);
        $display("%0d results compared, with sender, receiver and no idling and one long hold.",
                 results_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected", pending);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* four_channel_iir_lowpass_unit.f */
sv/fcil_pkg.sv
sv/fcil_datapath.sv
sv/fcil_state.sv
sv/four_channel_iir_lowpass_unit.sv
tb/fcil_iir_checker.sv
tb/four_channel_iir_lowpass_unit_tb.sv
